FILE: hdl/sftd_pkg.sv
// Shared types and constants for the sample format to double converter.
// Used by the core and every pipeline stage; depends on nothing.
package sftd_pkg;

   localparam logic [3:0] FMT_R8UNORM  = 4'd0;
   localparam logic [3:0] FMT_R8SNORM  = 4'd1;
   localparam logic [3:0] FMT_R8UINT   = 4'd2;
   localparam logic [3:0] FMT_R8SINT   = 4'd3;
   localparam logic [3:0] FMT_R16UNORM = 4'd4;
   localparam logic [3:0] FMT_R16SNORM = 4'd5;
   localparam logic [3:0] FMT_R16UINT  = 4'd6;
   localparam logic [3:0] FMT_R16SINT  = 4'd7;
   localparam logic [3:0] FMT_R16FLOAT = 4'd8;
   localparam logic [3:0] FMT_R32UINT  = 4'd9;
   localparam logic [3:0] FMT_R32SINT  = 4'd10;
   localparam logic [3:0] FMT_R32FLOAT = 4'd11;

   localparam logic [63:0] DBL_ONE   = 64'h3FF0_0000_0000_0000;
   localparam logic [63:0] DBL_QNAN  = 64'h7FF8_0000_0000_0000;
   localparam logic [10:0] EXP_ONES  = 11'h7FF;
   localparam logic [51:0] QUIET_BIT = 52'h8_0000_0000_0000;

   // Biased exponent of 0.S times 2^X is X + 1022 - lz; each BASE constant is X + 1022.
   localparam logic [10:0] BASE_FRAC = 11'd1022;
   localparam logic [10:0] BASE_INT  = 11'd1054;
   localparam logic [10:0] BASE_HALF = 11'd1008;
   localparam logic [10:0] BASE_SNGL = 11'd896;

   localparam int SIG_W = 80;

   typedef struct packed {
      logic              supported;
      logic              sign;
      logic              special;
      logic [63:0]       special_bits;
      logic [10:0]       exp_base;
      logic [4:0]        lz;
      logic [SIG_W-1:0]  sig;
   } stage_type;

endpackage

FILE: hdl/sftd_if.sv
// Handshake channels of the sample format converter.
// Does not depend on sftd_pkg; the widths are written out here.
interface sftd_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] raw_sample;
   modport source (output valid, output raw_sample, input ready);
   modport sink (input valid, input raw_sample, output ready);
endinterface

interface sftd_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] value_bits;
   logic        supported;
   modport source (output valid, output value_bits, output supported, input ready);
   modport sink (input valid, input value_bits, input supported, output ready);
endinterface

interface sftd_csr_if;
   logic       valid;
   logic       ready;
   logic [3:0] sample_format;
   modport source (output valid, output sample_format, input ready);
   modport sink (input valid, input sample_format, output ready);
endinterface

FILE: hdl/sample_format_to_double_core.sv
// Top level of the sample format to double converter: format register and
// four pipeline stages. Depends on sftd_pkg, the sftd interfaces and the stage modules.
//
//   channel   direction  carries
//   req_chan  in         raw_sample (32 bits)
//   rsp_chan  out        value_bits (64 bits), supported
//   csr_chan  in         sample_format (4 bits)
//
// Four register stages: decode, zero count, normalize, round and pack. A sample
// transferred on req_chan passes through all four registers before it is valid on rsp_chan.
// A new sample is taken every cycle unless a stall on rsp_chan has backed up to the decode stage;
// the stages hand off through valid bits. A stall on rsp_chan backs up stage by stage; empty stages still fill.
// Reset clears the valid bits and sets the format to r8unorm.
module sample_format_to_double_core (
   input logic              clock,
   input logic              reset,
   sftd_req_if.sink         req_chan,
   sftd_rsp_if.source       rsp_chan,
   sftd_csr_if.sink         csr_chan
);

   logic [3:0]          fmt_ff;
   logic                dec_valid, lzc_valid, sh_valid;
   logic                lzc_ready, sh_ready, rnd_ready;
   sftd_pkg::stage_type dec_data, lzc_data, sh_data;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff <= sftd_pkg::FMT_R8UNORM;
      end else if (csr_chan.valid) begin
         fmt_ff <= csr_chan.sample_format;
      end
   end

   sftd_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .fmt       (fmt_ff),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .raw       (req_chan.raw_sample),
      .out_valid (dec_valid),
      .out_ready (lzc_ready),
      .out_data  (dec_data)
   );

   sftd_lzc u_lzc (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dec_valid),
      .in_ready  (lzc_ready),
      .in_data   (dec_data),
      .out_valid (lzc_valid),
      .out_ready (sh_ready),
      .out_data  (lzc_data)
   );

   sftd_shift u_shift (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (lzc_valid),
      .in_ready  (sh_ready),
      .in_data   (lzc_data),
      .out_valid (sh_valid),
      .out_ready (rnd_ready),
      .out_data  (sh_data)
   );

   sftd_round u_round (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (sh_valid),
      .in_ready      (rnd_ready),
      .in_data       (sh_data),
      .out_valid     (rsp_chan.valid),
      .out_ready     (rsp_chan.ready),
      .out_bits      (rsp_chan.value_bits),
      .out_supported (rsp_chan.supported)
   );

   // An unsupported format must come out as all zero bits.
   a_unsupported_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.supported |-> rsp_chan.value_bits == 64'd0)
      else $error("unsupported format gave a nonzero value");

   // A configuration transfer lands in the format register on the next edge.
   a_format_write: assert property (@(posedge clock) disable iff (reset)
      csr_chan.valid |=> fmt_ff == $past(csr_chan.sample_format))
      else $error("format register missed a write");

   // A normalized non special significand has its leading one at the top.
   a_normalized: assert property (@(posedge clock) disable iff (reset)
      sh_valid && !sh_data.special |-> sh_data.sig[sftd_pkg::SIG_W-1])
      else $error("significand not normalized");

   // The pipeline comes out of reset empty.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid && !dec_valid)
      else $error("valid bit set right after reset");

endmodule

FILE: hdl/sftd_decode.sv
// First stage: decodes the raw sample under the format into sign, a left aligned
// significand string and a base exponent, or a finished special value. Uses sftd_pkg.
module sftd_decode (
   input  logic                clock,
   input  logic                reset,
   input  logic [3:0]          fmt,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [31:0]         raw,
   output logic                out_valid,
   input  logic                out_ready,
   output sftd_pkg::stage_type out_data
);

   logic                valid_ff;
   sftd_pkg::stage_type data_ff;
   sftd_pkg::stage_type data_in;

   logic [7:0]  mag8;
   logic [15:0] mag16;
   logic [31:0] mag32;
   logic [83:0] rep7;
   logic [89:0] rep15;

   always_comb begin
      mag8  = raw[7] ? 8'(-raw[7:0]) : raw[7:0];
      mag16 = raw[15] ? 16'(-raw[15:0]) : raw[15:0];
      mag32 = raw[31] ? 32'(-raw) : raw;
      rep7  = {12{mag8[6:0]}};
      rep15 = {6{mag16[14:0]}};

      data_in = '0;
      data_in.supported = 1'b1;
      case (fmt)
         sftd_pkg::FMT_R8UNORM: begin
            // v/255 is v repeated in every byte of the fraction.
            data_in.exp_base = sftd_pkg::BASE_FRAC;
            data_in.sig      = {10{raw[7:0]}};
            if (raw[7:0] == 8'd0) begin
               data_in.special = 1'b1;
            end else if (raw[7:0] == 8'hFF) begin
               data_in.special      = 1'b1;
               data_in.special_bits = sftd_pkg::DBL_ONE;
            end
         end
         sftd_pkg::FMT_R8SNORM: begin
            data_in.sign     = raw[7];
            data_in.exp_base = sftd_pkg::BASE_FRAC;
            data_in.sig      = rep7[83:4];
            if (mag8 == 8'd0) begin
               data_in.special = 1'b1;
            end else if (mag8 >= 8'd127) begin
               data_in.special      = 1'b1;
               data_in.special_bits = {raw[7], sftd_pkg::DBL_ONE[62:0]};
            end
         end
         sftd_pkg::FMT_R8UINT: begin
            data_in.exp_base = sftd_pkg::BASE_INT;
            data_in.sig      = {24'd0, raw[7:0], 48'd0};
            data_in.special  = (raw[7:0] == 8'd0);
         end
         sftd_pkg::FMT_R8SINT: begin
            data_in.sign     = raw[7];
            data_in.exp_base = sftd_pkg::BASE_INT;
            data_in.sig      = {24'd0, mag8, 48'd0};
            data_in.special  = (raw[7:0] == 8'd0);
         end
         sftd_pkg::FMT_R16UNORM: begin
            data_in.exp_base = sftd_pkg::BASE_FRAC;
            data_in.sig      = {5{raw[15:0]}};
            if (raw[15:0] == 16'd0) begin
               data_in.special = 1'b1;
            end else if (raw[15:0] == 16'hFFFF) begin
               data_in.special      = 1'b1;
               data_in.special_bits = sftd_pkg::DBL_ONE;
            end
         end
         sftd_pkg::FMT_R16SNORM: begin
            data_in.sign     = raw[15];
            data_in.exp_base = sftd_pkg::BASE_FRAC;
            data_in.sig      = rep15[89:10];
            if (mag16 == 16'd0) begin
               data_in.special = 1'b1;
            end else if (mag16 >= 16'd32767) begin
               data_in.special      = 1'b1;
               data_in.special_bits = {raw[15], sftd_pkg::DBL_ONE[62:0]};
            end
         end
         sftd_pkg::FMT_R16UINT: begin
            data_in.exp_base = sftd_pkg::BASE_INT;
            data_in.sig      = {16'd0, raw[15:0], 48'd0};
            data_in.special  = (raw[15:0] == 16'd0);
         end
         sftd_pkg::FMT_R16SINT: begin
            data_in.sign     = raw[15];
            data_in.exp_base = sftd_pkg::BASE_INT;
            data_in.sig      = {16'd0, mag16, 48'd0};
            data_in.special  = (raw[15:0] == 16'd0);
         end
         sftd_pkg::FMT_R16FLOAT: begin
            data_in.sign     = raw[15];
            data_in.exp_base = sftd_pkg::BASE_HALF;
            data_in.sig      = {raw[9:0], 70'd0};
            if (raw[14:10] == 5'd0) begin
               data_in.special      = (raw[9:0] == 10'd0);
               data_in.special_bits = {raw[15], 63'd0};
            end else if (raw[14:10] == 5'h1F) begin
               data_in.special      = 1'b1;
               data_in.special_bits = (raw[9:0] == 10'd0) ?
                                      {raw[15], sftd_pkg::EXP_ONES, 52'd0} :
                                      sftd_pkg::DBL_QNAN;
            end else begin
               data_in.special      = 1'b1;
               data_in.special_bits = {raw[15], 11'(raw[14:10]) + 11'd1008,
                                       raw[9:0], 42'd0};
            end
         end
         sftd_pkg::FMT_R32UINT: begin
            data_in.exp_base = sftd_pkg::BASE_INT;
            data_in.sig      = {raw, 48'd0};
            data_in.special  = (raw == 32'd0);
         end
         sftd_pkg::FMT_R32SINT: begin
            data_in.sign     = raw[31];
            data_in.exp_base = sftd_pkg::BASE_INT;
            data_in.sig      = {mag32, 48'd0};
            data_in.special  = (raw == 32'd0);
         end
         sftd_pkg::FMT_R32FLOAT: begin
            data_in.sign     = raw[31];
            data_in.exp_base = sftd_pkg::BASE_SNGL;
            data_in.sig      = {raw[22:0], 57'd0};
            if (raw[30:23] == 8'd0) begin
               data_in.special      = (raw[22:0] == 23'd0);
               data_in.special_bits = {raw[31], 63'd0};
            end else if (raw[30:23] == 8'hFF) begin
               data_in.special      = 1'b1;
               data_in.special_bits = (raw[22:0] == 23'd0) ?
                  {raw[31], sftd_pkg::EXP_ONES, 52'd0} :
                  {raw[31], sftd_pkg::EXP_ONES, {raw[22:0], 29'd0} | sftd_pkg::QUIET_BIT};
            end else begin
               data_in.special      = 1'b1;
               data_in.special_bits = {raw[31], 11'(raw[30:23]) + 11'd896,
                                       raw[22:0], 29'd0};
            end
         end
         default: begin
            data_in.supported = 1'b0;
            data_in.special   = 1'b1;
         end
      endcase
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

FILE: hdl/sftd_lzc.sv
// Second stage: counts the leading zeros of the significand string.
// The top 32 bits always hold the leading one of a non special item. Uses sftd_pkg.
module sftd_lzc (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  sftd_pkg::stage_type in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output sftd_pkg::stage_type out_data
);

   logic                valid_ff;
   sftd_pkg::stage_type data_ff;
   sftd_pkg::stage_type data_in;
   logic [4:0]          count;

   always_comb begin
      count = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (in_data.sig[sftd_pkg::SIG_W - 32 + i]) begin
            count = 5'(31 - i);
         end
      end
      data_in    = in_data;
      data_in.lz = count;
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

FILE: hdl/sftd_shift.sv
// Third stage: normalizes the significand so the leading one sits at the top
// and takes the zero count off the exponent. Uses sftd_pkg.
module sftd_shift (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  sftd_pkg::stage_type in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output sftd_pkg::stage_type out_data
);

   logic                valid_ff;
   sftd_pkg::stage_type data_ff;
   sftd_pkg::stage_type data_in;

   always_comb begin
      data_in          = in_data;
      data_in.sig      = in_data.sig << in_data.lz;
      data_in.exp_base = in_data.exp_base - 11'(in_data.lz);
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

FILE: hdl/sftd_round.sv
// Last stage: rounds to 52 fraction bits and packs the double into the output register.
// The repeating fractions of the normalized formats never tie. Uses sftd_pkg.
module sftd_round (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  sftd_pkg::stage_type in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [63:0]         out_bits,
   output logic                out_supported
);

   logic        valid_ff;
   logic [63:0] bits_ff;
   logic        supported_ff;
   logic [62:0] magnitude;
   logic [63:0] bits_in;

   always_comb begin
      // A carry out of the fraction bumps the exponent on its own.
      magnitude = {in_data.exp_base, in_data.sig[78:27]} + 63'(in_data.sig[26]);
      bits_in   = in_data.special ? in_data.special_bits : {in_data.sign, magnitude};
   end

   assign in_ready      = !valid_ff || out_ready;
   assign out_valid     = valid_ff;
   assign out_bits      = bits_ff;
   assign out_supported = supported_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_valid && in_ready) begin
         bits_ff      <= bits_in;
         supported_ff <= in_data.supported;
      end
   end

endmodule
